// ===== src/sct_pkg.sv =====
// shared constants and types for the taylor sine/cosine pipeline
// no dependencies; used by sct_term and sine_cosine_taylor_degrees
package sct_pkg;

  // series length and output format
  localparam int TERM_PAIRS    = 3;
  localparam int FRACTION_BITS = 16;
  localparam int LAST_TERM     = 3 + 4 * TERM_PAIRS;

  // input angle, q9.6 degrees
  localparam int IN_W  = 16;
  localparam int MAG_W = 15;
  localparam logic signed [IN_W-1:0] ANGLE_LIMIT = 16'sd23040;

  // degrees to radians: x = (mag * K + 2^11) >> 12, x in q24
  localparam int K_W       = 25;
  localparam logic [K_W-1:0] DEG_TO_RAD_K = 25'd18740330;
  localparam int RAD_SHIFT = 12;
  localparam int X_W       = 27;
  localparam int RAD_FRAC  = 24;

  // term magnitudes in q30
  localparam int WORK_BITS = 30;
  localparam int T_W       = 37;
  localparam int P_W       = T_W + X_W;
  localparam int Q_W       = P_W - RAD_FRAC;
  localparam int ACC_W     = 42;

  // constant divide by term index, two digits with remainder
  localparam int DIG_W = Q_W / 2;
  localparam int RB    = $clog2(LAST_TERM);
  localparam int VW    = RB + DIG_W;
  localparam int RS    = VW + RB;

  // output
  localparam int OUT_W = 20;
  localparam int SH    = WORK_BITS - FRACTION_BITS;

  // sign class of a term by its index mod 4
  localparam logic [1:0] COS_ADD = 2'd0;
  localparam logic [1:0] SIN_ADD = 2'd1;
  localparam logic [1:0] COS_SUB = 2'd2;
  localparam logic [1:0] SIN_SUB = 2'd3;

  typedef struct packed {
    logic                    neg;
    logic [X_W-1:0]          x;
    logic signed [ACC_W-1:0] sin_acc;
    logic signed [ACC_W-1:0] cos_acc;
  } carry_t;

  typedef struct packed {
    logic           vld;
    carry_t         carry;
    logic [T_W-1:0] term;
  } lane_t;

endpackage

// ===== src/sct_term.sv =====
// one series step: folds the previous term into the sums and derives the next
// term as floor(prev * x / (2^24 * n)); five register stages; uses sct_pkg
module sct_term (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [sct_pkg::RB-1:0]    divisor_i,
  input  logic [sct_pkg::RS-1:0]    recip_i,
  input  sct_pkg::lane_t            lane_i,
  output sct_pkg::lane_t            lane_o
);

  localparam int TL = (sct_pkg::T_W + 1) / 2;
  localparam int TH = sct_pkg::T_W - TL;

  // valid bits
  logic vld1_q, vld2_q, vld3_q, vld4_q, vld5_q;

  // carried payload per stage
  sct_pkg::carry_t carry1_d, carry1_q, carry2_q, carry3_q, carry4_q, carry5_q;

  // stage 1: split product
  logic [TL+sct_pkg::X_W-1:0] pplo1_d, pplo1_q;
  logic [TH+sct_pkg::X_W-1:0] pphi1_d, pphi1_q;
  // stage 2: dividend
  logic [sct_pkg::P_W-1:0]   prod2;
  logic [sct_pkg::Q_W-1:0]   q2_d, q2_q;
  // stage 3: high digit reciprocal product
  logic [sct_pkg::VW-1:0]            vhi3;
  logic [sct_pkg::VW+sct_pkg::RS-1:0] prod3_d, prod3_q;
  logic [sct_pkg::DIG_W-1:0]         qhi3_q, qlo3_q;
  // stage 4: high quotient digit and remainder
  logic [sct_pkg::DIG_W-1:0]          qdhi4_d, qdhi4_q, qlo4_q;
  logic [sct_pkg::DIG_W+sct_pkg::RB-1:0] qn4, rem4_full;
  logic [sct_pkg::RB-1:0]             rem4_d, rem4_q;
  // stage 5: low digit reciprocal product
  logic [sct_pkg::VW-1:0]             vlo5;
  logic [sct_pkg::VW+sct_pkg::RS-1:0] prod5_d, prod5_q;
  logic [sct_pkg::DIG_W-1:0]          qdhi5_q;
  logic [sct_pkg::Q_W-1:0]            quo5;

  logic [sct_pkg::RB-1:0]             prev_idx;
  logic signed [sct_pkg::ACC_W-1:0]   term_ext;

  // fold the incoming term into its sum
  always_comb begin
    prev_idx = divisor_i - {{(sct_pkg::RB-1){1'b0}}, 1'b1};
    term_ext = signed'({{(sct_pkg::ACC_W-sct_pkg::T_W){1'b0}}, lane_i.term});
    carry1_d = lane_i.carry;
    unique case (prev_idx[1:0])
      sct_pkg::SIN_ADD: begin
        carry1_d.sin_acc = lane_i.carry.sin_acc + term_ext;
      end
      sct_pkg::SIN_SUB: begin
        carry1_d.sin_acc = lane_i.carry.sin_acc - term_ext;
      end
      sct_pkg::COS_ADD: begin
        carry1_d.cos_acc = lane_i.carry.cos_acc + term_ext;
      end
      sct_pkg::COS_SUB: begin
        carry1_d.cos_acc = lane_i.carry.cos_acc - term_ext;
      end
    endcase
  end

  assign pplo1_d = lane_i.term[TL-1:0] * lane_i.carry.x;
  assign pphi1_d = lane_i.term[sct_pkg::T_W-1:TL] * lane_i.carry.x;

  assign prod2 = {pphi1_q, {TL{1'b0}}} + sct_pkg::P_W'(pplo1_q);
  assign q2_d  = prod2[sct_pkg::P_W-1 -: sct_pkg::Q_W];

  assign vhi3    = {{sct_pkg::RB{1'b0}}, q2_q[sct_pkg::Q_W-1 -: sct_pkg::DIG_W]};
  assign prod3_d = vhi3 * recip_i;

  assign qdhi4_d   = prod3_q[sct_pkg::RS +: sct_pkg::DIG_W];
  assign qn4       = qdhi4_d * divisor_i;
  assign rem4_full = {{sct_pkg::RB{1'b0}}, qhi3_q} - qn4;
  assign rem4_d    = rem4_full[sct_pkg::RB-1:0];

  assign vlo5    = {rem4_q, qlo4_q};
  assign prod5_d = vlo5 * recip_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
    end else begin
      vld1_q <= lane_i.vld;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
      vld4_q <= vld3_q;
      vld5_q <= vld4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    carry1_q <= carry1_d;
    pplo1_q  <= pplo1_d;
    pphi1_q  <= pphi1_d;
    carry2_q <= carry1_q;
    q2_q     <= q2_d;
    carry3_q <= carry2_q;
    prod3_q  <= prod3_d;
    qhi3_q   <= q2_q[sct_pkg::Q_W-1 -: sct_pkg::DIG_W];
    qlo3_q   <= q2_q[sct_pkg::DIG_W-1:0];
    carry4_q <= carry3_q;
    qdhi4_q  <= qdhi4_d;
    rem4_q   <= rem4_d;
    qlo4_q   <= qlo3_q;
    carry5_q <= carry4_q;
    prod5_q  <= prod5_d;
    qdhi5_q  <= qdhi4_q;
  end

  assign quo5 = {qdhi5_q, prod5_q[sct_pkg::RS +: sct_pkg::DIG_W]};

  assign lane_o.vld   = vld5_q;
  assign lane_o.carry = carry5_q;
  assign lane_o.term  = quo5[sct_pkg::T_W-1:0];

endmodule

// ===== src/sine_cosine_taylor_degrees.sv =====
// top level: taylor series sine and cosine of an angle in degrees
// depends on sct_pkg and sct_term
//
// usage
//   command channel: a transaction is taken at a rising edge with start_i high
//   and busy_o low; busy_o stays low, so a new angle may be issued every cycle
//   angle_degrees_i is signed q9.6 degrees, clamped to +/-360 degrees
//   result channel: done_o is high for exactly one cycle with sine_value_o,
//   cosine_value_o (signed, FRACTION_BITS fraction bits) and clipped_o
//   the receiver cannot hold results off, and the pipeline never stalls
//   path: front end registers a and b, the term steps, back end register g and
//   the output register lie between the start edge and the done edge
//   throughput: one transaction per cycle; each series term takes five
//   stages (split multiply, sum, two-digit reciprocal divide by the index)
//   reset: all valid bits clear, no result is pending afterwards
//   results leave in the order their angles came in
module sine_cosine_taylor_degrees (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic signed [sct_pkg::IN_W-1:0]  angle_degrees_i,
  output logic                             done_o,
  output logic signed [sct_pkg::OUT_W-1:0] sine_value_o,
  output logic signed [sct_pkg::OUT_W-1:0] cosine_value_o,
  output logic                             clipped_o
);

  localparam int RW = sct_pkg::ACC_W - sct_pkg::SH;

  // front end registers
  logic                       vld_a_q, vld_b_q;
  logic                       neg_a_q, neg_b_q;
  logic [sct_pkg::MAG_W-1:0]  mag_a_d, mag_a_q;
  logic [sct_pkg::X_W-1:0]    x_b_d, x_b_q;

  logic signed [sct_pkg::IN_W-1:0] ang_clamped, ang_abs;
  logic [sct_pkg::MAG_W+sct_pkg::K_W-1:0] rad_prod;

  // term chain, lane[k] carries term k+1
  sct_pkg::lane_t lane [sct_pkg::LAST_TERM];

  // back end registers
  logic                             vld_g_q;
  logic signed [sct_pkg::ACC_W-1:0] sin_g_d, sin_g_q, cos_g_q;
  logic signed [sct_pkg::ACC_W-1:0] sin_net, last_ext;

  logic signed [sct_pkg::ACC_W-1:0] sin_rnd, cos_rnd;
  logic [RW-1:0]                    sin_r, cos_r;
  logic [RW-sct_pkg::OUT_W:0]       sin_top, cos_top;
  logic                             sin_fit, cos_fit;
  logic [sct_pkg::OUT_W-1:0]        sin_sat, cos_sat;
  logic [sct_pkg::OUT_W-1:0]        out_max, out_min;

  logic                             done_q, clipped_q;
  logic [sct_pkg::OUT_W-1:0]        sine_q, cosine_q;

  // pipeline never holds off a command
  assign busy_o = 1'b0;

  // clamp and take magnitude
  always_comb begin
    ang_clamped = angle_degrees_i;
    if (angle_degrees_i > sct_pkg::ANGLE_LIMIT) begin
      ang_clamped = sct_pkg::ANGLE_LIMIT;
    end else if (angle_degrees_i < -sct_pkg::ANGLE_LIMIT) begin
      ang_clamped = -sct_pkg::ANGLE_LIMIT;
    end
    ang_abs = ang_clamped[sct_pkg::IN_W-1] ? -ang_clamped : ang_clamped;
    mag_a_d = ang_abs[sct_pkg::MAG_W-1:0];
  end

  // degrees to radians in q24, rounded
  assign rad_prod = mag_a_q * sct_pkg::DEG_TO_RAD_K
                  + (sct_pkg::MAG_W+sct_pkg::K_W)'(1 << (sct_pkg::RAD_SHIFT - 1));
  assign x_b_d    = rad_prod[sct_pkg::RAD_SHIFT +: sct_pkg::X_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      vld_a_q <= start_i & ~busy_o;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_a_d;
    neg_a_q <= angle_degrees_i[sct_pkg::IN_W-1];
    x_b_q   <= x_b_d;
    neg_b_q <= neg_a_q;
  end

  // first term is x itself in q30; sine sum starts empty, cosine sum at one
  assign lane[0].vld           = vld_b_q;
  assign lane[0].carry.neg     = neg_b_q;
  assign lane[0].carry.x       = x_b_q;
  assign lane[0].carry.sin_acc = '0;
  assign lane[0].carry.cos_acc = sct_pkg::ACC_W'(64'd1 << sct_pkg::WORK_BITS);
  assign lane[0].term          = sct_pkg::T_W'({x_b_q,
                                   {(sct_pkg::WORK_BITS-sct_pkg::RAD_FRAC){1'b0}}});

  // one step per series term, index n divides the term
  for (genvar n = 2; n <= sct_pkg::LAST_TERM; n++) begin : g_term
    localparam logic [sct_pkg::RB-1:0] DIV   = sct_pkg::RB'(n);
    localparam logic [sct_pkg::RS-1:0] RECIP =
      sct_pkg::RS'(((64'd1 << sct_pkg::RS) + 64'(n) - 64'd1) / 64'(n));

    sct_term u_term (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (DIV),
      .recip_i   (RECIP),
      .lane_i    (lane[n-2]),
      .lane_o    (lane[n-1])
    );
  end

  // last term always has index 3 mod 4, so it comes off the sine sum
  assign last_ext = signed'({{(sct_pkg::ACC_W-sct_pkg::T_W){1'b0}},
                             lane[sct_pkg::LAST_TERM-1].term});
  assign sin_net  = lane[sct_pkg::LAST_TERM-1].carry.sin_acc - last_ext;
  assign sin_g_d  = lane[sct_pkg::LAST_TERM-1].carry.neg ? -sin_net : sin_net;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_g_q <= 1'b0;
    end else begin
      vld_g_q <= lane[sct_pkg::LAST_TERM-1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sin_g_q <= sin_g_d;
    cos_g_q <= lane[sct_pkg::LAST_TERM-1].carry.cos_acc;
  end

  // round half up to the output fraction, then saturate
  always_comb begin
    out_max = {1'b0, {(sct_pkg::OUT_W-1){1'b1}}};
    out_min = {1'b1, {(sct_pkg::OUT_W-1){1'b0}}};
    sin_rnd = sin_g_q + signed'(sct_pkg::ACC_W'(64'd1 << (sct_pkg::SH - 1)));
    cos_rnd = cos_g_q + signed'(sct_pkg::ACC_W'(64'd1 << (sct_pkg::SH - 1)));
    sin_r   = sin_rnd[sct_pkg::ACC_W-1:sct_pkg::SH];
    cos_r   = cos_rnd[sct_pkg::ACC_W-1:sct_pkg::SH];
    sin_top = sin_r[RW-1:sct_pkg::OUT_W-1];
    cos_top = cos_r[RW-1:sct_pkg::OUT_W-1];
    // fits when every bit above the output sign matches it
    sin_fit = (&sin_top) | ~(|sin_top);
    cos_fit = (&cos_top) | ~(|cos_top);
    sin_sat = sin_fit ? sin_r[sct_pkg::OUT_W-1:0] : (sin_r[RW-1] ? out_min : out_max);
    cos_sat = cos_fit ? cos_r[sct_pkg::OUT_W-1:0] : (cos_r[RW-1] ? out_min : out_max);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sine_q    <= sin_sat;
    cosine_q  <= cos_sat;
    clipped_q <= ~sin_fit | ~cos_fit;
  end

  assign done_o         = done_q;
  assign sine_value_o   = signed'(sine_q);
  assign cosine_value_o = signed'(cosine_q);
  assign clipped_o      = clipped_q;

endmodule
